@@ rtl/core/days_between_dates_core_assert.svh @@
// Assertion macros used by the days-between-dates checker.
`ifndef DAYS_BETWEEN_DATES_CORE_ASSERT_SVH
`define DAYS_BETWEEN_DATES_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define DBD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define DBD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/dbd_pkg.sv @@
// Types and widths shared by the days-between-dates core.
`timescale 1ns / 1ps

package dbd_pkg;

	localparam int DAY_W    = 5;
	localparam int MONTH_W  = 4;
	localparam int YEAR_W   = 14;
	localparam int DIFF_W   = 23;
	localparam int DAYNUM_W = 23;
	localparam int PD_W     = 10;

	typedef struct packed {
		logic [DAY_W-1:0]   first_day;
		logic [MONTH_W-1:0] first_month;
		logic [YEAR_W-1:0]  first_year;
		logic [DAY_W-1:0]   second_day;
		logic [MONTH_W-1:0] second_month;
		logic [YEAR_W-1:0]  second_year;
	} dates_t;

	typedef struct packed {
		logic signed [DIFF_W-1:0] day_difference;
		logic                     order_error;
	} result_t;

endpackage

@@ rtl/core/days_between_dates_core.sv @@
// Top level: pipelined signed day count between two Gregorian dates.
//
// Usage: drive dates and raise start for one cycle per item; an item is taken
// at each rising edge with start high and busy low. busy stays low, so a new
// pair of dates may enter every cycle (one item per cycle sustained).
// Each item yields one result: done rises once the item has passed the v_s1,
// v_s2, v_s3 and done_s4 valid registers and stays high for exactly one cycle,
// with result valid in that cycle.
// The depth is set by the pipeline: input/order check, reciprocal divides,
// year-start count with month prefix, and the final subtract with saturation.
// result.day_difference is the signed day count, saturated at 4194303;
// on an order error (first year later, or same year and first month later)
// it is all ones and result.order_error is set.
// Reset clears all valid bits; items in flight are dropped and done is low.
// The receiver cannot stall: results are shown once and must be taken.
`timescale 1ns / 1ps

module days_between_dates_core import dbd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  dates_t  dates,
	output logic    done,
	output result_t result
);

	localparam logic [MONTH_W-1:0] MONTH_AFTER_DEC = 4'd13;
	localparam logic [MONTH_W-1:0] MONTH_JAN       = 4'd1;
	localparam int                 SUM_W           = DAYNUM_W + 2;
	localparam logic signed [SUM_W-1:0] DIFF_MAX   = SUM_W'(4194303);

	logic                accept;
	logic                same_year, err;
	logic [MONTH_W-1:0]  sel1, sel2;

	logic                v_s1, v_s2, v_s3, done_s4;
	logic                err_s1, err_s2, err_s3;
	logic [YEAR_W-1:0]   y1_s1, y2_s1;
	logic [MONTH_W-1:0]  m1_s1, m2_s1;
	logic [DAY_W-1:0]    d1_s1, d2_s1;
	result_t             result_s4;

	logic [DAYNUM_W-1:0] dn1, dn2;
	logic [PD_W-1:0]     pd1, pd2;
	logic [SUM_W-1:0]    diff;
	logic [DIFF_W-1:0]   diff_sat;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Stage 1: order check; clamp months so both dates share one day-number formula
	always_comb begin
		same_year = dates.first_year == dates.second_year;
		err = (dates.first_year > dates.second_year) ||
		      (same_year && (dates.first_month > dates.second_month));
		sel1 = dates.first_month;
		sel2 = dates.second_month;
		if (!same_year) begin
			if (dates.first_month > MONTH_AFTER_DEC)
				sel1 = MONTH_AFTER_DEC;
			if (dates.second_month < MONTH_JAN)
				sel2 = MONTH_JAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			done_s4 <= 1'b0;
		end else begin
			v_s1    <= accept;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			done_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		err_s1 <= err;
		y1_s1  <= dates.first_year;
		y2_s1  <= dates.second_year;
		m1_s1  <= sel1;
		m2_s1  <= sel2;
		d1_s1  <= dates.first_day;
		d2_s1  <= dates.second_day;
		err_s2 <= err_s1;
		err_s3 <= err_s2;
	end

	// Stages 2 and 3: one day-number unit per date
	dbd_year_unit u_first (
		.clk     (clk),
		.year    (y1_s1),
		.month   (m1_s1),
		.day     (d1_s1),
		.day_num (dn1),
		.in_year (pd1)
	);

	dbd_year_unit u_second (
		.clk     (clk),
		.year    (y2_s1),
		.month   (m2_s1),
		.day     (d2_s1),
		.day_num (dn2),
		.in_year (pd2)
	);

	// Stage 4: subtract, saturate high, apply error code
	always_comb begin
		diff = SUM_W'(dn2) - SUM_W'(dn1) + SUM_W'(pd2) - SUM_W'(pd1);
		if ($signed(diff) > DIFF_MAX)
			diff_sat = DIFF_MAX[DIFF_W-1:0];
		else
			diff_sat = diff[DIFF_W-1:0];
	end

	always_ff @(posedge clk) begin
		result_s4.order_error    <= err_s3;
		result_s4.day_difference <= err_s3 ? '1 : diff_sat;
	end

	assign done   = done_s4;
	assign result = result_s4;

endmodule

@@ rtl/core/dbd_year_unit.sv @@
// Two-stage day-number unit: days from year 0 to a date's month start, plus day offset.
`timescale 1ns / 1ps

module dbd_year_unit import dbd_pkg::*; (
	input  logic                clk,
	input  logic [YEAR_W-1:0]   year,
	input  logic [MONTH_W-1:0]  month,
	input  logic [DAY_W-1:0]    day,
	output logic [DAYNUM_W-1:0] day_num,
	output logic [PD_W-1:0]     in_year
);

	localparam logic [12:0] DIV100_MUL = 13'd5243;
	localparam int          DIV100_SH  = 19;
	localparam logic [14:0] HUNDRED    = 15'd100;

	// floor(x / 100) for x below 25600
	function automatic logic [7:0] div100(input logic [14:0] x);
		logic [27:0] p;
		p = 28'(x) * 28'(DIV100_MUL);
		return p[DIV100_SH+7:DIV100_SH];
	endfunction

	// Month-start offsets with a 28-day February; months 0, 2, 13 and 14 count as February.
	function automatic logic [8:0] month_base(input logic [MONTH_W-1:0] m);
		logic [8:0] b;
		case (m)
			4'd0:    b = 9'd0;
			4'd1:    b = 9'd28;
			4'd2:    b = 9'd59;
			4'd3:    b = 9'd87;
			4'd4:    b = 9'd118;
			4'd5:    b = 9'd148;
			4'd6:    b = 9'd179;
			4'd7:    b = 9'd209;
			4'd8:    b = 9'd240;
			4'd9:    b = 9'd271;
			4'd10:   b = 9'd301;
			4'd11:   b = 9'd332;
			4'd12:   b = 9'd362;
			4'd13:   b = 9'd393;
			4'd14:   b = 9'd421;
			default: b = 9'd449;
		endcase
		return b;
	endfunction

	logic [14:0] sum99, sum399, hund, quarter;
	logic [DAYNUM_W-1:0] mul365;
	logic [2:0]  feb_below;
	logic [8:0]  prefix;
	logic        leap;

	logic [YEAR_W-1:0]  year_s2;
	logic [MONTH_W-1:0] month_s2;
	logic [DAY_W-1:0]   day_s2;
	logic [7:0]         qc100_s2, qc400_s2, qf100_s2;

	logic [DAYNUM_W-1:0] day_num_s3;
	logic [PD_W-1:0]     in_year_s3;

	// Stage 2: ceilings of y/100 and y/400, floor of y/100
	assign sum99  = 15'(year) + 15'd99;
	assign sum399 = 15'(year) + 15'd399;

	always_ff @(posedge clk) begin
		year_s2  <= year;
		month_s2 <= month;
		day_s2   <= day;
		qc100_s2 <= div100(sum99);
		qc400_s2 <= div100({2'b00, sum399[14:2]});
		qf100_s2 <= div100(15'(year));
	end

	// Stage 3: leap flag, year start count, month prefix
	assign hund    = 15'(qf100_s2) * HUNDRED;
	assign leap    = (year_s2[1:0] == 2'b00) &&
	                 ((15'(year_s2) != hund) || (qf100_s2[1:0] == 2'b00));
	assign quarter = (15'(year_s2) + 15'd3) >> 2;
	assign mul365  = DAYNUM_W'(year_s2) * DAYNUM_W'(365);

	always_comb begin
		feb_below = 3'(month_s2 > 4'd0) + 3'(month_s2 > 4'd2) +
		            3'(month_s2 > 4'd13) + 3'(month_s2 > 4'd14);
		prefix = month_base(month_s2) + (leap ? 9'(feb_below) : 9'd0);
	end

	// Measure the offset from January 1 (less month 0) plus 29, so it never goes negative
	always_ff @(posedge clk) begin
		day_num_s3 <= mul365 + DAYNUM_W'(quarter) - DAYNUM_W'(qc100_s2)
		              + DAYNUM_W'(qc400_s2);
		in_year_s3 <= PD_W'(prefix) + PD_W'(day_s2) + PD_W'(!leap);
	end

	assign day_num = day_num_s3;
	assign in_year = in_year_s3;

endmodule

@@ rtl/core/dbd_checker.sv @@
// Port-level checker for the days-between-dates core, bound to the top level.
`timescale 1ns / 1ps
`include "days_between_dates_core_assert.svh"

module dbd_checker import dbd_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input dates_t  dates,
	input logic    done,
	input result_t result
);

	`DBD_ASSERT_SAME(a_err_code, done && result.order_error, result.day_difference == '1, "order error without all-ones code")
	`DBD_ASSERT_SAME(a_latency, start && !busy, ##4 done, "result beat missing four edges after accept")
	`DBD_ASSERT_SAME(a_err_flag, done, result.order_error == $past((dates.first_year > dates.second_year) || ((dates.first_year == dates.second_year) && (dates.first_month > dates.second_month)), 4), "order error flag does not match dates")
	`DBD_ASSERT_NEXT(a_no_spurious, !(start && !busy), ##3 !done || (result.order_error || $signed(result.day_difference) > -32), "result beat or value out of range")

endmodule

bind days_between_dates_core dbd_checker u_dbd_checker (.*);

@@ tb/tb_top.sv @@
// Self-checking testbench for the days-between-dates core.
`timescale 1ns / 1ps

module tb_top;
	import dbd_pkg::*;

	localparam int DIFF_CEIL = (1 << (DIFF_W - 1)) - 1;
	localparam int ITEM_GOAL = 1400;

	typedef struct packed {
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
	} date_t;

	// Holds the day counts owed by the core, oldest first.
	class day_count_board;
		result_t owed[$];
		int      errors;

		function new();
			errors = 0;
		endfunction

		static function int month_days(int m, int y);
			bit leap;
			leap = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
			case (m)
				1, 3, 5, 7, 8, 10, 12: return 31;
				4, 6, 9, 11: return 30;
				default: return leap ? 29 : 28;
			endcase
		endfunction

		// Months lo..hi inclusive; empty when lo > hi.
		function int month_span(int lo, int hi, int y);
			int s;
			s = 0;
			if (lo < 0) lo = 0;
			if (hi > 15) hi = 15;
			for (int i = lo; i <= hi; i++)
				s += month_days(i, y);
			return s;
		endfunction

		// Leap years in 0..y, year 0 included.
		function int leap_count(int y);
			return y / 4 - y / 100 + y / 400 + 1;
		endfunction

		function result_t days_between(dates_t d);
			result_t r;
			int d1, m1, y1, d2, m2, y2, diff;
			d1 = int'(d.first_day);
			m1 = int'(d.first_month);
			y1 = int'(d.first_year);
			d2 = int'(d.second_day);
			m2 = int'(d.second_month);
			y2 = int'(d.second_year);
			r.order_error = 1'b0;
			if (y1 > y2 || (y1 == y2 && m1 > m2)) begin
				r.order_error = 1'b1;
				diff = -1;
			end else if (y1 == y2) begin
				diff = month_span(m1, m2 - 1, y1) - d1 + d2;
			end else begin
				diff = month_span(m1, 12, y1) - d1;
				diff += month_span(1, m2 - 1, y2) + d2;
				diff += 365 * (y2 - y1 - 1) + leap_count(y2 - 1) - leap_count(y1);
			end
			if (diff > DIFF_CEIL) diff = DIFF_CEIL;
			r.day_difference = diff[DIFF_W-1:0];
			return r;
		endfunction

		function void note_dates(dates_t d);
			owed.push_back(days_between(d));
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (owed.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual diff %0d err %0b",
					$time, $signed(got.day_difference), got.order_error);
				errors++;
				return;
			end
			want = owed.pop_front();
			if (got.day_difference !== want.day_difference) begin
				$display("%0t: day_difference mismatch: expected %0d, actual %0d",
					$time, $signed(want.day_difference), $signed(got.day_difference));
				errors++;
			end
			if (got.order_error !== want.order_error) begin
				$display("%0t: order_error mismatch: expected %0b, actual %0b",
					$time, want.order_error, got.order_error);
				errors++;
			end
		endfunction

		function void flag_leftovers();
			if (owed.size() != 0) begin
				$display("%0t: missing results: expected %0d more, actual 0",
					$time, owed.size());
				errors++;
			end
		endfunction
	endclass

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	logic    done;
	dates_t  dates;
	result_t result;

	day_count_board board;

	days_between_dates_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.dates  (dates),
		.done   (done),
		.result (result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Take every result beat on the edge that ends its cycle.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			board.check_result(result);
	end

	function automatic dates_t pair(int d1, int m1, int y1, int d2, int m2, int y2);
		dates_t d;
		d.first_day    = DAY_W'(d1);
		d.first_month  = MONTH_W'(m1);
		d.first_year   = YEAR_W'(y1);
		d.second_day   = DAY_W'(d2);
		d.second_month = MONTH_W'(m2);
		d.second_year  = YEAR_W'(y2);
		return d;
	endfunction

	function automatic int pick_year();
		int y;
		if ($urandom_range(0, 4) == 0) begin
			y = 100 * $urandom_range(0, 99) + $urandom_range(0, 5) - 1;
			if (y < 0) y = 0;
		end else begin
			y = $urandom_range(0, 9999);
		end
		return y;
	endfunction

	function automatic date_t valid_date();
		date_t dt;
		dt.year  = YEAR_W'(pick_year());
		dt.month = MONTH_W'($urandom_range(1, 12));
		dt.day   = DAY_W'($urandom_range(1,
			day_count_board::month_days(int'(dt.month), int'(dt.year))));
		return dt;
	endfunction

	function automatic dates_t pick_dates();
		date_t       a, b, t;
		logic [63:0] bits;
		dates_t      raw;
		int          r;
		r = $urandom_range(0, 99);
		a = valid_date();
		b = valid_date();
		if (r < 20) begin
			b.year = a.year;
			if (r < 7) b.month = a.month;
			b.day = DAY_W'($urandom_range(1,
				day_count_board::month_days(int'(b.month), int'(b.year))));
		end
		if (r < 72) begin
			if ({a.year, a.month} > {b.year, b.month}) begin
				t = a;
				a = b;
				b = t;
			end
		end else if (r < 84) begin
			if ({a.year, a.month} < {b.year, b.month}) begin
				t = a;
				a = b;
				b = t;
			end
		end else begin
			bits = {$urandom, $urandom};
			raw = bits[$bits(dates_t)-1:0];
			return raw;
		end
		return dates_t'({a, b});
	endfunction

	task automatic send_dates(input dates_t d);
		@(negedge clk);
		start <= 1'b1;
		dates <= d;
		do @(posedge clk); while (busy);
		board.note_dates(d);
	endtask

	task automatic hold_off(input int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task automatic wait_drained();
		while (board.owed.size() != 0)
			@(posedge clk);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	initial begin
		dates_t directed[$];
		bit     burst;
		board  = new();
		clk    = 1'b0;
		arst_n = 1'b0;
		start  = 1'b0;
		dates  = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		directed.push_back(pair(1, 1, 0, 31, 12, 9999));
		directed.push_back(pair(31, 12, 9999, 1, 1, 0));      // later year
		directed.push_back(pair(15, 6, 2000, 15, 3, 2000));   // same year, later month
		directed.push_back(pair(20, 5, 2023, 3, 5, 2023));    // same month, goes negative
		directed.push_back(pair(1, 1, 2024, 1, 1, 2024));
		directed.push_back(pair(28, 2, 1900, 1, 3, 1900));    // century, not leap
		directed.push_back(pair(28, 2, 2000, 1, 3, 2000));    // 400 rule, leap
		directed.push_back(pair(29, 2, 0, 1, 3, 0));          // year zero is leap
		directed.push_back(pair(31, 12, 1999, 1, 1, 2000));
		directed.push_back(pair(0, 1, 2020, 31, 2, 2021));    // days out of range
		directed.push_back(pair(31, 2, 2021, 0, 4, 2021));
		directed.push_back(pair(10, 0, 2004, 10, 0, 2005));   // month zero both sides
		directed.push_back(pair(1, 13, 2003, 5, 15, 2004));   // first month past December
		directed.push_back(pair(1, 15, 2010, 1, 15, 2010));
		directed.push_back(pair(1, 0, 2012, 31, 15, 2012));
		directed.push_back(pair(1, 1, 10000, 31, 12, 16383)); // long span, below saturation
		directed.push_back(pair(0, 0, 0, 31, 15, 16383));
		directed.push_back(pair(31, 15, 16383, 0, 0, 0));
		directed.push_back(pair(31, 15, 16383, 31, 15, 16383));
		directed.push_back(pair(5, 0, 1, 2, 0, 1));
		directed.push_back(pair(1, 1, 0, 1, 1, 1));
		directed.push_back(pair(1, 12, 9999, 1, 1, 10000));
		foreach (directed[i])
			send_dates(directed[i]);

		burst = 1'b0;
		for (int n = 0; n < ITEM_GOAL; n++) begin
			if (n % 100 == 0) burst = ($urandom_range(0, 3) == 0);
			// Let the pipe run dry once mid-run.
			if (n == ITEM_GOAL / 2) begin
				hold_off(1);
				wait_drained();
			end
			send_dates(pick_dates());
			if (!burst) hold_off(pick_gap());
		end
		hold_off(1);

		wait_drained();
		repeat (8) @(posedge clk);
		board.flag_leftovers();
		if (board.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#5000000;
		$display("FAILURE");
		$finish;
	end

endmodule

@@ days_between_dates_core.f @@
+incdir+rtl/core
rtl/core/dbd_pkg.sv
rtl/core/dbd_year_unit.sv
rtl/core/days_between_dates_core.sv
rtl/core/dbd_checker.sv
tb/tb_top.sv
